[hdl/pipi_pkg.sv]
package pipi_pkg;

    // field widths
    localparam int ROUNDS_W = 16;
    localparam int SETTLE_W = 8;
    localparam int VBUS_W   = 16;
    localparam int PERIOD_W = 20;
    localparam int CUR_W    = 16;
    localparam int SUM_W    = 33;
    localparam int TOTAL_W  = SUM_W + 2;
    localparam int DEN_W    = TOTAL_W - 1;
    localparam int PROD1_W  = VBUS_W + PERIOD_W;
    localparam int PROD2_W  = PROD1_W + ROUNDS_W;
    localparam int NUM_W    = PROD2_W + 1;
    localparam int RES_W    = 32;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    // apb register map
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_TARGET_ROUNDS = 2'd0;
    localparam logic [1:0] REG_SETTLE_TICKS  = 2'd1;
    localparam logic [1:0] REG_BUS_VOLTAGE   = 2'd2;
    localparam logic [1:0] REG_CARRIER_NS    = 2'd3;

    // register reset values
    localparam logic [ROUNDS_W-1:0] RST_TARGET_ROUNDS = 16'd100;
    localparam logic [SETTLE_W-1:0] RST_SETTLE_TICKS  = 8'd50;
    localparam logic [VBUS_W-1:0]   RST_BUS_VOLTAGE   = 16'd24000;
    localparam logic [PERIOD_W-1:0] RST_CARRIER_NS    = 20'd50000;

    typedef struct packed {
        logic signed [CUR_W-1:0] current_a_ma;
        logic signed [CUR_W-1:0] current_b_ma;
        logic signed [CUR_W-1:0] current_c_ma;
    } in_t;

    typedef struct packed {
        logic             drive_a_high;
        logic             drive_b_high;
        logic             drive_c_high;
        logic             finished;
        logic [RES_W-1:0] inductance_nh;
        logic             fault;
    } out_t;

    typedef struct packed {
        logic [ROUNDS_W-1:0] target_rounds;
        logic [SETTLE_W-1:0] settle_ticks;
        logic [VBUS_W-1:0]   bus_voltage_mv;
        logic [PERIOD_W-1:0] carrier_period_ns;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic tick;
        logic mul_vp;
        logic mul_r;
        logic div_start;
        logic load_fault;
        logic load_quot;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic report_req;
        logic total_pos;
        logic div_done;
    } status_t;

endpackage

[hdl/pipi_div.sv]
module pipi_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [pipi_pkg::NUM_W-1:0] num,
    input  logic [pipi_pkg::DEN_W-1:0] den,
    output logic                       done,
    output logic [pipi_pkg::NUM_W-1:0] quo
);
    import pipi_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 fits;

    // one restoring step per cycle, quotient bits shift in as dividend shifts out
    always_comb begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        diff      = trial - {1'b0, den};
        fits      = (trial >= {1'b0, den});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[hdl/pipi_dpath.sv]
module pipi_dpath (
    input  logic               aclk,
    input  logic               aresetn,
    input  pipi_pkg::cfg_t     cfg,
    input  pipi_pkg::in_t      in_data,
    input  pipi_pkg::cmd_t     cmd,
    output pipi_pkg::status_t  status,
    output pipi_pkg::out_t     out_data
);
    import pipi_pkg::*;

    localparam logic [3:0] STEP_WAIT_A   = 4'd0;
    localparam logic [3:0] STEP_OFF      = 4'd1;
    localparam logic [3:0] STEP_PULSE_A  = 4'd2;
    localparam logic [3:0] STEP_SAMPLE_A = 4'd3;
    localparam logic [3:0] STEP_WAIT_B   = 4'd4;
    localparam logic [3:0] STEP_PULSE_B  = 4'd5;
    localparam logic [3:0] STEP_SAMPLE_B = 4'd6;
    localparam logic [3:0] STEP_WAIT_C   = 4'd7;
    localparam logic [3:0] STEP_PULSE_C  = 4'd8;
    localparam logic [3:0] STEP_SAMPLE_C = 4'd9;
    localparam logic [3:0] STEP_ROUND    = 4'd10;

    // drive pattern bits: bit0 a, bit1 b, bit2 c
    localparam logic [2:0] PAT_OFF = 3'b000;
    localparam logic [2:0] PAT_A   = 3'b001;
    localparam logic [2:0] PAT_B   = 3'b010;
    localparam logic [2:0] PAT_C   = 3'b100;

    logic [3:0]              step_reg, step_next;
    logic [SETTLE_W-1:0]     wait_reg, wait_next;
    logic [ROUNDS_W-1:0]     rounds_reg, rounds_next;
    logic signed [SUM_W-1:0] sum_a_reg, sum_a_next;
    logic signed [SUM_W-1:0] sum_b_reg, sum_b_next;
    logic signed [SUM_W-1:0] sum_c_reg, sum_c_next;
    logic [2:0]              drive_reg, drive_next;
    logic                    reported_reg, reported_next;
    logic [SETTLE_W-1:0]     wait_inc;
    logic                    running;

    logic [PROD1_W-1:0]        prod1_reg;
    logic [PROD2_W-1:0]        prod2_reg;
    logic signed [TOTAL_W-1:0] total;
    logic                      div_done;
    logic [NUM_W-1:0]          quo;
    out_t                      out_reg, out_next;

    assign running  = (rounds_reg < cfg.target_rounds);
    assign wait_inc = wait_reg + 1'b1;

    // pulse sequencer, advanced once per tick
    always_comb begin
        step_next     = step_reg;
        wait_next     = wait_reg;
        rounds_next   = rounds_reg;
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        sum_c_next    = sum_c_reg;
        drive_next    = drive_reg;
        reported_next = reported_reg;
        if (cmd.tick) begin
            if (running) begin
                unique case (step_reg)
                    STEP_WAIT_A, STEP_WAIT_B, STEP_WAIT_C: begin
                        if (wait_inc >= cfg.settle_ticks) begin
                            wait_next = '0;
                            step_next = step_reg + 1'b1;
                        end else begin
                            wait_next = wait_inc;
                        end
                    end
                    STEP_OFF: begin
                        drive_next = PAT_OFF;
                        step_next  = step_reg + 1'b1;
                    end
                    STEP_PULSE_A: begin
                        drive_next = PAT_B | PAT_C;
                        step_next  = step_reg + 1'b1;
                    end
                    STEP_SAMPLE_A: begin
                        sum_a_next = sum_a_reg + SUM_W'(in_data.current_a_ma);
                        drive_next = PAT_OFF;
                        step_next  = step_reg + 1'b1;
                    end
                    STEP_PULSE_B: begin
                        drive_next = PAT_A | PAT_C;
                        step_next  = step_reg + 1'b1;
                    end
                    STEP_SAMPLE_B: begin
                        sum_b_next = sum_b_reg + SUM_W'(in_data.current_b_ma);
                        drive_next = PAT_OFF;
                        step_next  = step_reg + 1'b1;
                    end
                    STEP_PULSE_C: begin
                        drive_next = PAT_A | PAT_B;
                        step_next  = step_reg + 1'b1;
                    end
                    STEP_SAMPLE_C: begin
                        sum_c_next = sum_c_reg + SUM_W'(in_data.current_c_ma);
                        drive_next = PAT_OFF;
                        step_next  = step_reg + 1'b1;
                    end
                    STEP_ROUND: begin
                        rounds_next = rounds_reg + 1'b1;
                        step_next   = STEP_WAIT_A;
                    end
                    default: begin
                        step_next = STEP_WAIT_A;
                    end
                endcase
            end else begin
                drive_next    = PAT_OFF;
                reported_next = 1'b1;
            end
        end
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= STEP_WAIT_A;
            wait_reg     <= '0;
            rounds_reg   <= '0;
            sum_a_reg    <= '0;
            sum_b_reg    <= '0;
            sum_c_reg    <= '0;
            drive_reg    <= PAT_OFF;
            reported_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            wait_reg     <= wait_next;
            rounds_reg   <= rounds_next;
            sum_a_reg    <= sum_a_next;
            sum_b_reg    <= sum_b_next;
            sum_c_reg    <= sum_c_next;
            drive_reg    <= drive_next;
            reported_reg <= reported_next;
        end
    end

    // current total, held steady while the result is worked out
    assign total = TOTAL_W'(sum_a_reg) + TOTAL_W'(sum_b_reg) + TOTAL_W'(sum_c_reg);

    // numerator in two multiply stages: vbus * period, then * rounds
    always_ff @(posedge aclk) begin
        if (cmd.mul_vp) begin
            prod1_reg <= PROD1_W'(cfg.bus_voltage_mv) * PROD1_W'(cfg.carrier_period_ns);
        end
        if (cmd.mul_r) begin
            prod2_reg <= PROD2_W'(prod1_reg) * PROD2_W'(rounds_reg);
        end
    end

    pipi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     ({prod2_reg, 1'b0}),
        .den     (total[DEN_W-1:0]),
        .done    (div_done),
        .quo     (quo)
    );

    // result register
    always_comb begin
        out_next = out_reg;
        if (cmd.tick) begin
            out_next.drive_a_high  = drive_next[0];
            out_next.drive_b_high  = drive_next[1];
            out_next.drive_c_high  = drive_next[2];
            out_next.finished      = 1'b0;
            out_next.inductance_nh = '0;
            out_next.fault         = 1'b0;
        end else if (cmd.load_fault) begin
            out_next.finished      = 1'b1;
            out_next.inductance_nh = '0;
            out_next.fault         = 1'b1;
        end else if (cmd.load_quot) begin
            out_next.finished      = 1'b1;
            out_next.inductance_nh = (|quo[NUM_W-1:RES_W]) ? '1 : quo[RES_W-1:0];
            out_next.fault         = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign out_data          = out_reg;
    assign status.report_req = !running && !reported_reg;
    assign status.total_pos  = !total[TOTAL_W-1] && (|total);
    assign status.div_done   = div_done;

endmodule

[hdl/pipi_ctrl.sv]
module pipi_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  pipi_pkg::status_t status,
    output pipi_pkg::cmd_t    cmd
);
    import pipi_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MUL_VP   = 3'd1;
    localparam logic [2:0] ST_MUL_R    = 3'd2;
    localparam logic [2:0] ST_DIV_GO   = 3'd3;
    localparam logic [2:0] ST_DIV_WAIT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;

    // a new request is taken in idle once the result slot is free or draining
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.tick = 1'b1;
                    if (status.report_req) begin
                        state_next = ST_MUL_VP;
                    end else begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            ST_MUL_VP: begin
                if (status.total_pos) begin
                    cmd.mul_vp = 1'b1;
                    state_next = ST_MUL_R;
                end else begin
                    cmd.load_fault = 1'b1;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_MUL_R: begin
                cmd.mul_r  = 1'b1;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    cmd.load_quot = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[hdl/phase_inductance_pulse_identifier_top.sv]
// phase inductance identifier, voltage pulse method
// s_ channel: one request per pwm tick carrying the three phase current samples.
// m_ channel: exactly one result per request, with the phase drive commands in
//   force after that tick; finished pulses once with inductance_nh and fault.
// apb port: target_rounds at 0x0, settle_ticks at 0x4, bus_voltage_mv at 0x8,
//   carrier_period_ns at 0xc; write only while the block is idle.
// an ordinary tick's result is valid in the cycle after it is accepted.
// the reporting tick runs the vbus*period and *rounds multiply steps and a
//   restoring divider that retires one quotient bit per cycle for 53 bits;
//   a non-positive current sum skips the divider and reports a fault.
// throughput: one request at a time; the next is taken in the cycle the previous
//   result is taken, so with m_ready high ordinary ticks run at one per cycle.
// a stalled receiver holds the result in the output register and s_ready
//   stays low until it is taken.
// reset: synchronous active-low aresetn clears the sequencer, sums, round count
//   and drive pattern and loads the register defaults; m_data is not reset.
module phase_inductance_pulse_identifier_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  pipi_pkg::in_t                s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output pipi_pkg::out_t               m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pipi_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import pipi_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    cmd_t    cmd;
    status_t status;
    logic    wr_en;

    // register writes
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[3:2])
                REG_TARGET_ROUNDS: cfg_next.target_rounds     = pwdata[ROUNDS_W-1:0];
                REG_SETTLE_TICKS:  cfg_next.settle_ticks      = pwdata[SETTLE_W-1:0];
                REG_BUS_VOLTAGE:   cfg_next.bus_voltage_mv    = pwdata[VBUS_W-1:0];
                REG_CARRIER_NS:    cfg_next.carrier_period_ns = pwdata[PERIOD_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_rounds     <= RST_TARGET_ROUNDS;
            cfg_reg.settle_ticks      <= RST_SETTLE_TICKS;
            cfg_reg.bus_voltage_mv    <= RST_BUS_VOLTAGE;
            cfg_reg.carrier_period_ns <= RST_CARRIER_NS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // register reads
    always_comb begin
        unique case (paddr[3:2])
            REG_TARGET_ROUNDS: prdata = 32'(cfg_reg.target_rounds);
            REG_SETTLE_TICKS:  prdata = 32'(cfg_reg.settle_ticks);
            REG_BUS_VOLTAGE:   prdata = 32'(cfg_reg.bus_voltage_mv);
            REG_CARRIER_NS:    prdata = 32'(cfg_reg.carrier_period_ns);
            default:           prdata = '0;
        endcase
    end

    pipi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pipi_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_data  (s_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (m_data)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import pipi_pkg::*;

    // sequencer steps of one three-phase round
    localparam logic [3:0] STEP_WAIT_A    = 4'd0;
    localparam logic [3:0] STEP_OFF_A     = 4'd1;
    localparam logic [3:0] STEP_PULSE_A   = 4'd2;
    localparam logic [3:0] STEP_SAMPLE_A  = 4'd3;
    localparam logic [3:0] STEP_WAIT_B    = 4'd4;
    localparam logic [3:0] STEP_PULSE_B   = 4'd5;
    localparam logic [3:0] STEP_SAMPLE_B  = 4'd6;
    localparam logic [3:0] STEP_WAIT_C    = 4'd7;
    localparam logic [3:0] STEP_PULSE_C   = 4'd8;
    localparam logic [3:0] STEP_SAMPLE_C  = 4'd9;
    localparam logic [3:0] STEP_ROUND_END = 4'd10;

    // phase drive bits
    localparam logic [2:0] DRV_OFF = 3'b000;
    localparam logic [2:0] DRV_A   = 3'b001;
    localparam logic [2:0] DRV_B   = 3'b010;
    localparam logic [2:0] DRV_C   = 3'b100;

    localparam int STALL_CYCLES = 300;

    // how the single report of the run is reached
    typedef enum int {
        END_NORMAL,
        END_SATURATE,
        END_FAULT,
        END_ZERO_TARGET
    } end_plan_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_t                 s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_t                m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    phase_inductance_pulse_identifier_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // pending current ticks and the drive/report results they must produce
    in_t  pending_ticks[$];
    out_t predicted_drive[$];

    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    int          tx_pct = 0;
    int          rx_pct = 0;
    int          stall_left = 0;
    int          stall_asked = 0;
    int          stall_served = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          ticks_accepted = 0;
    int          finished_seen = 0;
    int          cfg_writes = 0;

    // identifier state as predicted
    cfg_t               cfg_m;
    logic [3:0]         seq_step;
    logic [7:0]         settle_cnt;
    logic [15:0]        rounds_cnt;
    logic signed [32:0] sum_ia;
    logic signed [32:0] sum_ib;
    logic signed [32:0] sum_ic;
    logic [2:0]         drive_now;
    logic               report_sent;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("phase_inductance_pulse_identifier_top regression: fail");
        $finish;
    end

    function automatic longint current_total();
        longint total;
        total = sum_ia + sum_ib + sum_ic;
        return total;
    endfunction

    // advance the sequencer by one pwm tick and form its result
    function automatic out_t identify_tick(input in_t tick);
        out_t            res;
        longint          total;
        longint unsigned num;
        longint unsigned quot;
        res = '0;
        if (rounds_cnt < cfg_m.target_rounds) begin
            case (seq_step)
                STEP_WAIT_A, STEP_WAIT_B, STEP_WAIT_C: begin
                    settle_cnt = settle_cnt + 8'd1;
                    if (settle_cnt >= cfg_m.settle_ticks) begin
                        settle_cnt = '0;
                        seq_step = seq_step + 4'd1;
                    end
                end
                STEP_OFF_A: begin
                    drive_now = DRV_OFF;
                    seq_step = seq_step + 4'd1;
                end
                STEP_PULSE_A: begin
                    drive_now = DRV_B | DRV_C;
                    seq_step = seq_step + 4'd1;
                end
                STEP_SAMPLE_A: begin
                    sum_ia = sum_ia + $signed(tick.current_a_ma);
                    drive_now = DRV_OFF;
                    seq_step = seq_step + 4'd1;
                end
                STEP_PULSE_B: begin
                    drive_now = DRV_A | DRV_C;
                    seq_step = seq_step + 4'd1;
                end
                STEP_SAMPLE_B: begin
                    sum_ib = sum_ib + $signed(tick.current_b_ma);
                    drive_now = DRV_OFF;
                    seq_step = seq_step + 4'd1;
                end
                STEP_PULSE_C: begin
                    drive_now = DRV_A | DRV_B;
                    seq_step = seq_step + 4'd1;
                end
                STEP_SAMPLE_C: begin
                    sum_ic = sum_ic + $signed(tick.current_c_ma);
                    drive_now = DRV_OFF;
                    seq_step = seq_step + 4'd1;
                end
                STEP_ROUND_END: begin
                    rounds_cnt = rounds_cnt + 16'd1;
                    seq_step = STEP_WAIT_A;
                end
                default: begin
                    seq_step = STEP_WAIT_A;
                end
            endcase
        end else begin
            // target reached: all phases off, report only the first time
            drive_now = DRV_OFF;
            if (!report_sent) begin
                report_sent = 1'b1;
                res.finished = 1'b1;
                total = current_total();
                if (total <= 0) begin
                    res.fault = 1'b1;
                end else begin
                    num = 64'd2 * cfg_m.bus_voltage_mv * cfg_m.carrier_period_ns * rounds_cnt;
                    quot = num / longint'(total);
                    res.inductance_nh = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
                end
            end
        end
        res.drive_a_high = |(drive_now & DRV_A);
        res.drive_b_high = |(drive_now & DRV_B);
        res.drive_c_high = |(drive_now & DRV_C);
        return res;
    endfunction

    function automatic logic [15:0] pick_current();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 20));
            3: return 16'(-$urandom_range(1, 20));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic in_t random_tick();
        in_t t;
        t.current_a_ma = pick_current();
        t.current_b_ma = pick_current();
        t.current_c_ma = pick_current();
        return t;
    endfunction

    // random tick whose sampled phase current pulls the sum toward goal
    function automatic in_t steered_tick(input longint goal);
        in_t    t;
        longint d;
        t = random_tick();
        d = goal - current_total();
        if (d > 32767) begin
            d = 32767;
        end else if (d < -32768) begin
            d = -32768;
        end
        if (rounds_cnt < cfg_m.target_rounds) begin
            case (seq_step)
                STEP_SAMPLE_A: t.current_a_ma = d[15:0];
                STEP_SAMPLE_B: t.current_b_ma = d[15:0];
                STEP_SAMPLE_C: t.current_c_ma = d[15:0];
                default: ;
            endcase
        end
        return t;
    endfunction

    function automatic int unsigned pick_gap(input int pct);
        return ($urandom_range(0, 99) < pct) ? $urandom_range(0, 18) : 0;
    endfunction

    function automatic string fmt_out(input out_t o);
        return $sformatf("drv=%b%b%b fin=%b ind=%0d flt=%b", o.drive_a_high, o.drive_b_high,
                         o.drive_c_high, o.finished, o.inductance_nh, o.fault);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic offer_tick(input in_t t);
        pending_ticks.push_back(t);
        predicted_drive.push_back(identify_tick(t));
    endtask

    // wait until every tick is taken and every result is back
    task automatic wait_idle();
        while (pending_ticks.size() != 0 || s_valid || predicted_drive.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // apb write, sometimes with junk above the field width, then read back
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] field_val);
        logic [31:0] value;
        logic [31:0] want;
        logic [31:0] rd;
        int          w;
        case (idx)
            REG_TARGET_ROUNDS: w = ROUNDS_W;
            REG_SETTLE_TICKS:  w = SETTLE_W;
            REG_BUS_VOLTAGE:   w = VBUS_W;
            default:           w = PERIOD_W;
        endcase
        value = field_val;
        if ($urandom_range(0, 1)) begin
            value = value | ($urandom() << w);
        end
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_writes++;
        want = value & ((32'd1 << w) - 32'd1);
        case (idx)
            REG_TARGET_ROUNDS: cfg_m.target_rounds     = want[ROUNDS_W-1:0];
            REG_SETTLE_TICKS:  cfg_m.settle_ticks      = want[SETTLE_W-1:0];
            REG_BUS_VOLTAGE:   cfg_m.bus_voltage_mv    = want[VBUS_W-1:0];
            default:           cfg_m.carrier_period_ns = want[PERIOD_W-1:0];
        endcase
        // read back
        @(posedge aclk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        rd = prdata;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== want) begin
            flag_mismatch($sformatf("register %0d read back: expected %h, got %h", idx, want, rd));
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                ticks_accepted++;
            end
            if (tx_gap != 0) begin
                s_valid <= 1'b0;
                tx_gap  <= tx_gap - 1;
            end else if (pending_ticks.size() != 0) begin
                s_data  <= pending_ticks.pop_front();
                s_valid <= 1'b1;
                tx_gap  <= pick_gap(tx_pct);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (stall_asked != stall_served) begin
            stall_left   <= STALL_CYCLES;
            stall_served <= stall_served + 1;
        end
    end

    // result monitor and receiver
    always @(posedge aclk) begin : rx_side
        int unsigned gap_next;
        out_t        want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap  <= 0;
        end else begin
            gap_next = (rx_gap != 0) ? rx_gap - 1 : 0;
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_data.finished) begin
                    finished_seen++;
                end
                if (predicted_drive.size() == 0) begin
                    flag_mismatch({"result with none expected: ", fmt_out(m_data)});
                end else begin
                    want = predicted_drive.pop_front();
                    if (m_data.drive_a_high !== want.drive_a_high
                        || m_data.drive_b_high !== want.drive_b_high
                        || m_data.drive_c_high !== want.drive_c_high
                        || m_data.finished !== want.finished
                        || m_data.inductance_nh !== want.inductance_nh
                        || m_data.fault !== want.fault) begin
                        flag_mismatch($sformatf("result %0d: expected %s, got %s", results_seen,
                                                fmt_out(want), fmt_out(m_data)));
                    end
                end
                gap_next = pick_gap(rx_pct);
            end
            rx_gap  <= gap_next;
            m_ready <= (gap_next == 0) && (stall_left == 0);
        end
    end

    initial begin : stimulus
        end_plan_t   plan;
        in_t         t;
        logic [15:0] corner_vals[6];
        int          r;
        int          len;
        int          rand_items;
        int          phase_no;
        int          guard;
        longint      goal_total;
        logic [31:0] tgt;
        logic [31:0] bus;
        logic [31:0] period;

        corner_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555};
        cfg_m.target_rounds     = RST_TARGET_ROUNDS;
        cfg_m.settle_ticks      = RST_SETTLE_TICKS;
        cfg_m.bus_voltage_mv    = RST_BUS_VOLTAGE;
        cfg_m.carrier_period_ns = RST_CARRIER_NS;
        seq_step    = STEP_WAIT_A;
        settle_cnt  = '0;
        rounds_cnt  = '0;
        sum_ia      = '0;
        sum_ib      = '0;
        sum_ic      = '0;
        drive_now   = DRV_OFF;
        report_sent = 1'b0;
        rand_items  = 0;
        phase_no    = 0;

        r = $urandom_range(0, 5);
        plan = (r < 3) ? END_NORMAL : (r == 3) ? END_SATURATE :
               (r == 4) ? END_FAULT : END_ZERO_TARGET;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // a few ticks on the reset defaults
        repeat (4) offer_tick(random_tick());
        wait_idle();

        // zero target right after reset: immediate report with fault
        if (plan == END_ZERO_TARGET) begin
            write_reg(REG_TARGET_ROUNDS, 32'd0);
            repeat (3) offer_tick(random_tick());
            wait_idle();
        end

        // directed: zero settle time, top register values, corner currents
        write_reg(REG_TARGET_ROUNDS, 32'hFFFF);
        write_reg(REG_SETTLE_TICKS, 32'd0);
        write_reg(REG_BUS_VOLTAGE, 32'hFFFF);
        write_reg(REG_CARRIER_NS, 32'hFFFFF);
        for (int i = 0; i < 22; i++) begin
            t.current_a_ma = corner_vals[i % 6];
            t.current_b_ma = corner_vals[(i + 1) % 6];
            t.current_c_ma = corner_vals[(i + 3) % 6];
            offer_tick(t);
        end
        wait_idle();

        // random phases, each with its own register settings
        while (rand_items < 600) begin
            if (!report_sent && rand_items >= 250) begin
                // steer the current sum to a chosen total at a round boundary, then report
                write_reg(REG_TARGET_ROUNDS, 32'hFFFF);
                write_reg(REG_SETTLE_TICKS, $urandom_range(0, 1));
                if (plan == END_SATURATE) begin
                    write_reg(REG_BUS_VOLTAGE, 32'hFFFF);
                    write_reg(REG_CARRIER_NS, 32'hFFFFF);
                    goal_total = 1;
                end else begin
                    write_reg(REG_BUS_VOLTAGE, $urandom_range(0, 65535));
                    write_reg(REG_CARRIER_NS, $urandom_range(1, 1000000));
                    if (plan == END_FAULT) begin
                        goal_total = ($urandom_range(0, 2) == 0) ? 0 :
                                     -longint'($urandom_range(1, 200000));
                    end else begin
                        goal_total = $urandom_range(1, 400000);
                    end
                end
                tx_pct = 30 * $urandom_range(0, 3);
                rx_pct = 30 * $urandom_range(0, 3);
                guard = 0;
                while (guard < 1500 && !(current_total() == goal_total
                       && seq_step == STEP_WAIT_A && settle_cnt == 0)) begin
                    offer_tick(steered_tick(goal_total));
                    guard++;
                end
                rand_items += guard;
                wait_idle();
                write_reg(REG_TARGET_ROUNDS, 32'(rounds_cnt));
                repeat (4) offer_tick(random_tick());
                rand_items += 4;
                wait_idle();
            end

            // settle: mostly short, sometimes the maximum
            r = $urandom_range(0, 9);
            if (r < 6) begin
                write_reg(REG_SETTLE_TICKS, $urandom_range(0, 3));
            end else if (r < 9) begin
                write_reg(REG_SETTLE_TICKS, $urandom_range(4, 12));
            end else begin
                write_reg(REG_SETTLE_TICKS, 32'd255);
            end
            len = (cfg_m.settle_ticks == 8'd255) ? 40 : $urandom_range(20, 80);

            // target: far ahead before the report; afterwards resume or hold
            if (!report_sent) begin
                tgt = $urandom_range(int'(rounds_cnt) + 16, 65535);
            end else begin
                case ($urandom_range(0, 3))
                    0: tgt = 32'd1;
                    1: tgt = 32'(rounds_cnt);
                    2: tgt = 32'hFFFF;
                    default: tgt = (rounds_cnt > 16'hFFF0) ? 32'hFFFF :
                                   32'(rounds_cnt) + $urandom_range(1, 4);
                endcase
            end
            write_reg(REG_TARGET_ROUNDS, tgt);

            case ($urandom_range(0, 3))
                0: bus = 32'd0;
                1: bus = 32'hFFFF;
                default: bus = $urandom_range(0, 65535);
            endcase
            write_reg(REG_BUS_VOLTAGE, bus);
            case ($urandom_range(0, 4))
                0: period = 32'd1;
                1: period = 32'd1000000;
                2: period = 32'hFFFFF;
                default: period = $urandom_range(1, 1000000);
            endcase
            write_reg(REG_CARRIER_NS, period);

            tx_pct = 30 * $urandom_range(0, 3);
            rx_pct = 30 * $urandom_range(0, 3);
            // one phase with a long receiver hold while requests keep coming
            if (phase_no == 1) begin
                tx_pct = 0;
                if (len < 60) begin
                    len = 60;
                end
                stall_asked++;
            end
            repeat (len) offer_tick(random_tick());
            rand_items += len;
            phase_no++;
            wait_idle();
        end

        wait_idle();
        $display("run covered %0d tick requests over %0d random phases, %0d results checked",
                 ticks_accepted, phase_no, results_seen);
        $display("report path %s, finished seen %0d time(s), %0d register writes",
                 plan.name(), finished_seen, cfg_writes);
        if (mismatches == 0 && predicted_drive.size() == 0) begin
            $display("phase_inductance_pulse_identifier_top regression: pass");
        end else begin
            $display("phase_inductance_pulse_identifier_top regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/pipi_pkg.sv
hdl/pipi_div.sv
hdl/pipi_dpath.sv
hdl/pipi_ctrl.sv
hdl/phase_inductance_pulse_identifier_top.sv
tb/tb_top.sv
